### src/qcr_pkg.sv
package qcr_pkg;

	localparam int DEF_SAMPLE_WIDTH    = 16;
	localparam int DEF_PHASE_WIDTH     = 32;
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int FREQ_WIDTH          = 32;
	localparam int GAIN_WIDTH          = 32;
	localparam int CFG_INDEX_WIDTH     = 2;
	localparam int SINE_AMP            = 32767;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREQ_MAX   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FREQ_MIN   = 2'd3;

	localparam logic [31:0] RST_PROP_GAIN  = 32'd111621000;
	localparam logic [31:0] RST_INTEG_GAIN = 32'd4294000;
	localparam logic [31:0] RST_FREQ_MAX   = 32'sd683565276;
	localparam logic [31:0] RST_FREQ_MIN   = -32'sd683565276;

	typedef struct packed {
		logic load;
		logic rotate;
		logic detect;
		logic update;
	} qcr_cmd_t;

	// Q30 Taylor series of sin, evaluated at elaboration for constant tables
	function automatic longint unsigned quarter_sine(input longint unsigned r, input int tbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned a;
		x = (r * 64'd6746518852) >> tbits;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd210;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
		t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		a = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (a > 64'd32767) begin
			a = 64'd32767;
		end
		return a;
	endfunction

endpackage

### src/qcr_ctrl.sv
module qcr_ctrl
	import qcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output qcr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ROTATE = 3'd1;
	localparam logic [2:0] ST_DETECT = 3'd2;
	localparam logic [2:0] ST_HOLD   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				cmd.rotate = 1'b1;
				state_d = ST_DETECT;
			end
			ST_DETECT: begin
				cmd.detect = 1'b1;
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.update = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/qcr_datapath.sv
module qcr_datapath
	import qcr_pkg::*;
#(
	parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
	parameter int PHASE_WIDTH     = DEF_PHASE_WIDTH,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qcr_cmd_t                       cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] in_i,
	input  logic signed [SAMPLE_WIDTH-1:0] in_q,
	input  logic                           in_last,
	input  logic        [GAIN_WIDTH-1:0]   prop_gain,
	input  logic        [GAIN_WIDTH-1:0]   integ_gain,
	input  logic signed [FREQ_WIDTH-1:0]   freq_max,
	input  logic signed [FREQ_WIDTH-1:0]   freq_min,
	output logic signed [SAMPLE_WIDTH-1:0] out_i,
	output logic signed [SAMPLE_WIDTH-1:0] out_q,
	output logic signed [FREQ_WIDTH-1:0]   out_freq,
	output logic                           out_last
);

	localparam int N    = 1 << SINE_TABLE_BITS;
	localparam int QTR  = N / 4;
	localparam int QB   = SINE_TABLE_BITS - 2;
	localparam int PW   = SAMPLE_WIDTH + 18;
	localparam int EW   = SAMPLE_WIDTH;
	localparam int GPW  = GAIN_WIDTH + EW + 1;
	localparam int FW   = FREQ_WIDTH + 2;
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef logic [15:0] qsine_tab_t [QTR+1];

	function automatic qsine_tab_t build_tab();
		qsine_tab_t tb;
		for (int r = 0; r <= QTR; r++) begin
			tb[r] = 16'(quarter_sine(64'(r), SINE_TABLE_BITS));
		end
		return tb;
	endfunction

	localparam qsine_tab_t QSINE = build_tab();

	function automatic logic signed [16:0] lut_sine(input logic [SINE_TABLE_BITS-1:0] k);
		logic [1:0]  q;
		logic [QB:0] r;
		logic [16:0] v;
		q = k[SINE_TABLE_BITS-1 -: 2];
		r = {1'b0, k[QB-1:0]};
		if (q[0]) begin
			r = (QB+1)'(QTR) - r;
		end
		v = {1'b0, QSINE[r]};
		return q[1] ? -$signed(v) : $signed(v);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		sh = (p + PW'(1 <<< 14)) >>> 15;
		if (sh > PW'(SMAX)) begin
			return SMAX;
		end else if (sh < $signed(PW'(SMIN))) begin
			return SMIN;
		end
		return sh[SAMPLE_WIDTH-1:0];
	endfunction

	logic        [PHASE_WIDTH-1:0]  phase_q;
	logic signed [FREQ_WIDTH-1:0]   freq_q;
	logic signed [SAMPLE_WIDTH-1:0] xi_q, xq_q;
	logic                           last_q;
	logic signed [16:0]             sn_q, cs_q;
	logic signed [PW-1:0]           pi_q, pq_q;
	logic signed [GPW-1:0]          df_q, dp_q;
	logic signed [SAMPLE_WIDTH-1:0] oi_q, oq_q;

	logic [SINE_TABLE_BITS-1:0] k;
	logic signed [SAMPLE_WIDTH-1:0] oi, oq;
	logic signed [EW+1:0]          e_w;
	logic signed [EW-1:0]          e;
	logic signed [FW-1:0]          f;
	logic signed [FREQ_WIDTH-1:0]  f_cl;

	assign k  = phase_q[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
	assign oi = rnd_sat(pi_q);
	assign oq = rnd_sat(pq_q);

	always_comb begin
		e_w = ((oi > 0) ? (EW+2)'(oq) : -(EW+2)'(oq))
			- ((oq > 0) ? (EW+2)'(oi) : -(EW+2)'(oi));
		if (e_w > (EW+2)'(SMAX)) begin
			e = SMAX;
		end else if (e_w < $signed((EW+2)'(SMIN))) begin
			e = SMIN;
		end else begin
			e = e_w[EW-1:0];
		end
		f = FW'(freq_q) + FW'(df_q >>> (SAMPLE_WIDTH - 1));
		if (f > FW'(freq_max)) begin
			f_cl = freq_max;
		end else if (f < FW'(freq_min)) begin
			f_cl = freq_min;
		end else begin
			f_cl = f[FREQ_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			freq_q <= '0;
		end else if (cmd.update) begin
			phase_q <= phase_q + PHASE_WIDTH'(dp_q >>> (SAMPLE_WIDTH - 1)) + PHASE_WIDTH'(f);
			freq_q <= f_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xi_q <= in_i;
			xq_q <= in_q;
			last_q <= in_last;
			sn_q <= lut_sine(k);
			cs_q <= lut_sine(k + SINE_TABLE_BITS'(QTR));
		end
		if (cmd.rotate) begin
			pi_q <= PW'(xi_q) * PW'(cs_q) + PW'(xq_q) * PW'(sn_q);
			pq_q <= PW'(xq_q) * PW'(cs_q) - PW'(xi_q) * PW'(sn_q);
		end
		if (cmd.detect) begin
			oi_q <= oi;
			oq_q <= oq;
			df_q <= $signed({1'b0, integ_gain}) * e;
			dp_q <= $signed({1'b0, prop_gain}) * e;
		end
		if (cmd.update) begin
			out_i <= oi_q;
			out_q <= oq_q;
			out_freq <= f_cl;
			out_last <= last_q;
		end
	end

endmodule

### src/qpsk_costas_carrier_recovery_top.sv
// An accepted input word is loaded, rotated and detected, then registered to the output
// by the loop update; no new word is taken before that update, as the phase/frequency
// feedback through the sine lookup, complex multiply, detector and gain multiply needs it.
// An unaccepted output word stalls the loop update until taken.
// Reset (arst_n low): phase and frequency clear, gains and clamps reload defaults.
module qpsk_costas_carrier_recovery_top
	import qcr_pkg::*;
#(
	parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
	parameter int PHASE_WIDTH     = DEF_PHASE_WIDTH,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_i,
	input  logic signed [SAMPLE_WIDTH-1:0] in_q,
	input  logic                           in_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] out_i,
	output logic signed [SAMPLE_WIDTH-1:0] out_q,
	output logic signed [FREQ_WIDTH-1:0]   out_freq,
	output logic                           out_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [31:0]                    cfg_data
);

	qcr_cmd_t cmd;
	logic [GAIN_WIDTH-1:0]        prop_gain_q, integ_gain_q;
	logic signed [FREQ_WIDTH-1:0] freq_max_q, freq_min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= RST_PROP_GAIN;
			integ_gain_q <= RST_INTEG_GAIN;
			freq_max_q <= RST_FREQ_MAX;
			freq_min_q <= RST_FREQ_MIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				REG_FREQ_MAX:   freq_max_q <= cfg_data;
				REG_FREQ_MIN:   freq_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	qcr_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.PHASE_WIDTH    (PHASE_WIDTH),
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_i      (in_i),
		.in_q      (in_q),
		.in_last   (in_last),
		.prop_gain (prop_gain_q),
		.integ_gain(integ_gain_q),
		.freq_max  (freq_max_q),
		.freq_min  (freq_min_q),
		.out_i     (out_i),
		.out_q     (out_q),
		.out_freq  (out_freq),
		.out_last  (out_last)
	);

endmodule

### src/qcr_checker.sv
module qcr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_freq
);

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input taken twice in a row");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("output too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_freq))
		else $error("output word dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##2 !in_ready) else $error("input reopened early");

endmodule

bind qpsk_costas_carrier_recovery_top qcr_checker u_qcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_freq (out_freq)
);

### dv/qpsk_costas_carrier_recovery_top_tb.sv
`timescale 1ns / 100ps

module qpsk_costas_carrier_recovery_top_tb;
	import qcr_pkg::*;

	localparam int SW = DEF_SAMPLE_WIDTH;

	typedef struct {
		logic signed [SW-1:0] i;
		logic signed [SW-1:0] q;
		logic                 last;
	} sample_t;

	typedef struct {
		logic signed [SW-1:0]         i;
		logic signed [SW-1:0]         q;
		logic signed [FREQ_WIDTH-1:0] freq;
		logic                         last;
	} derot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SW-1:0] in_i = '0;
	logic signed [SW-1:0] in_q = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SW-1:0] out_i;
	logic signed [SW-1:0] out_q;
	logic signed [FREQ_WIDTH-1:0] out_freq;
	logic out_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	sample_t samples_pending[$];
	derot_t  derot_expected[$];
	longint  sine_lut[1024];
	logic [31:0] nco_ph;
	longint      loop_f;
	logic [31:0] alpha_g, beta_g, f_hi, f_lo;
	int errors = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int rx_hold = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;

	qpsk_costas_carrier_recovery_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_i(in_i), .in_q(in_q), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_i(out_i), .out_q(out_q), .out_freq(out_freq), .out_last(out_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint first_quadrant_sine(longint unsigned r);
		longint unsigned x, x2, acc, prod, amp;
		longint unsigned divs[7];
		divs = '{210, 156, 110, 72, 42, 20, 6};
		x = (r * 64'd6746518852) >> 10;
		x2 = (x * x) >> 30;
		acc = 64'd1 << 30;
		foreach (divs[n])
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / divs[n];
		prod = (x * acc) >> 30;
		amp = (prod * 64'd32767 + (64'd1 << 29)) >> 30;
		if (amp > 64'd32767)
			amp = 64'd32767;
		return longint'(amp);
	endfunction

	function automatic longint clip_sample(longint v);
		longint hi;
		hi = (longint'(1) << (SW - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic derotate_and_track(input sample_t s);
		int unsigned k, kc;
		longint sn, cs, xi, xq, oi, oq, e, df, dp, f, v;
		derot_t d;
		k = 32'(nco_ph[31:22]);
		for (int w = 0; w < 2; w++) begin
			kc = (w == 0) ? k : ((k + 256) & 1023);
			v = sine_lut[kc];
			if (w == 0) sn = v; else cs = v;
		end
		xi = longint'(s.i);
		xq = longint'(s.q);
		oi = clip_sample((xi * cs + xq * sn + (longint'(1) << 14)) >>> 15);
		oq = clip_sample((xq * cs - xi * sn + (longint'(1) << 14)) >>> 15);
		e = clip_sample((oi > 0 ? oq : -oq) - (oq > 0 ? oi : -oi));
		df = (longint'({32'b0, beta_g}) * e) >>> (SW - 1);
		dp = (longint'({32'b0, alpha_g}) * e) >>> (SW - 1);
		f = loop_f + df;
		nco_ph = nco_ph + dp[31:0] + f[31:0];
		if (f > longint'($signed(f_hi)))
			f = longint'($signed(f_hi));
		else if (f < longint'($signed(f_lo)))
			f = longint'($signed(f_lo));
		loop_f = f;
		d.i = oi[SW-1:0];
		d.q = oq[SW-1:0];
		d.freq = f[31:0];
		d.last = s.last;
		derot_expected.insert(derot_expected.size(), d);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		bit nv;
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				s.i = in_i;
				s.q = in_q;
				s.last = in_last;
				derotate_and_track(s);
				nv = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (samples_pending.size() > 0) begin
					s = samples_pending.pop_front();
					in_i <= s.i;
					in_q <= s.q;
					in_last <= s.last;
					nv = 1'b1;
					tx_gap = pick_gap(tx_burst);
				end
			end
			in_valid <= nv;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		derot_t d;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (derot_expected.size() == 0) begin
					$error("unexpected output word i=%0d q=%0d", out_i, out_q);
					errors++;
				end else begin
					d = derot_expected.pop_front();
					if (out_i !== d.i) begin
						$error("out_i expected %0d actual %0d", d.i, out_i);
						errors++;
					end
					if (out_q !== d.q) begin
						$error("out_q expected %0d actual %0d", d.q, out_q);
						errors++;
					end
					if (out_freq !== d.freq) begin
						$error("out_freq expected %0d actual %0d", d.freq, out_freq);
						errors++;
					end
					if (out_last !== d.last) begin
						$error("out_last expected %0d actual %0d", d.last, out_last);
						errors++;
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				rx_stall = pick_gap(rx_burst);
				out_ready <= (rx_stall == 0);
			end
		end
	end

	task automatic push_sample(int i, int q, bit last);
		sample_t s;
		s.i = SW'(clip_sample(i));
		s.q = SW'(clip_sample(q));
		s.last = last;
		samples_pending.insert(samples_pending.size(), s);
	endtask

	task automatic push_random(int n);
		int amp, sel, ni, nq;
		for (int c = 0; c < n; c++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				amp = $urandom_range(500, 30000);
				ni = int'($urandom_range(0, 2000)) - 1000;
				nq = int'($urandom_range(0, 2000)) - 1000;
				push_sample(($urandom_range(0, 1) ? amp : -amp) + ni,
					($urandom_range(0, 1) ? amp : -amp) + nq, $urandom_range(0, 15) == 0);
			end else if (sel < 90) begin
				push_sample($signed(16'($urandom)), $signed(16'($urandom)), $urandom_range(0, 1));
			end else begin
				push_sample($urandom_range(0, 1) ? -32768 : $urandom_range(0, 1) ? 32767 : 0,
					$urandom_range(0, 1) ? -32768 : $urandom_range(0, 1) ? 32767 : 0,
					$urandom_range(0, 1));
			end
		end
	endtask

	task automatic drain();
		while (samples_pending.size() > 0 || in_valid || derot_expected.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PROP_GAIN:  alpha_g = val;
			REG_INTEG_GAIN: beta_g = val;
			REG_FREQ_MAX:   f_hi = val;
			REG_FREQ_MIN:   f_lo = val;
		endcase
	endtask

	task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] hi, logic [31:0] lo);
		write_reg(REG_PROP_GAIN, a);
		write_reg(REG_INTEG_GAIN, b);
		write_reg(REG_FREQ_MAX, hi);
		write_reg(REG_FREQ_MIN, lo);
	endtask

	initial begin
		for (int k = 0; k < 1024; k++) begin
			sine_lut[k] = first_quadrant_sine(k[8] ? 256 - (k & 255) : (k & 255));
			if (k[9])
				sine_lut[k] = -sine_lut[k];
		end
		nco_ph = '0;
		loop_f = 0;
		alpha_g = RST_PROP_GAIN;
		beta_g = RST_INTEG_GAIN;
		f_hi = RST_FREQ_MAX;
		f_lo = RST_FREQ_MIN;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_sample(0, 0, 0);
		push_sample(32767, 32767, 1);
		push_sample(-32768, -32768, 0);
		push_sample(32767, -32768, 1);
		push_sample(-32768, 32767, 0);
		push_sample(0, 20000, 0);
		push_sample(20000, 0, 0);
		push_sample(0, -20000, 1);
		push_sample(-20000, 0, 0);
		push_sample(23170, 23170, 0);
		push_sample(-23170, 23170, 0);
		push_sample(-23170, -23170, 0);
		push_sample(23170, -23170, 1);
		push_sample(1, -1, 0);
		push_sample(-1, 1, 1);
		push_sample(32767, 0, 0);
		push_sample(0, -32768, 0);
		push_sample(-32768, 1, 1);
		push_random(180);
		drain();

		write_all($urandom, $urandom_range(0, 32'h00ffffff), 32'sd300000000, -32'sd300000000);
		push_random(200);
		drain();

		write_all(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000);
		tx_burst = 1;
		rx_hold = 300;
		push_random(200);
		drain();
		tx_burst = 0;

		write_all(32'd0, 32'd0, 32'd0, 32'd0);
		push_random(150);
		drain();

		write_all($urandom, $urandom, 32'sd1000, 32'sd5000);
		rx_burst = 1;
		push_random(200);
		drain();
		rx_burst = 0;

		write_all($urandom, $urandom, $urandom, $urandom);
		push_random(200);
		drain();

		write_all(32'd0, 32'hffffffff, 32'h7fffffff, 32'h80000000);
		tx_burst = 1;
		rx_burst = 1;
		push_random(150);
		drain();
		tx_burst = 0;
		rx_burst = 0;

		write_all(RST_PROP_GAIN, RST_INTEG_GAIN, RST_FREQ_MAX, RST_FREQ_MIN);
		push_random(350);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("** qpsk_costas_carrier_recovery_top: PASSED **");
		else
			$display("** qpsk_costas_carrier_recovery_top: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** qpsk_costas_carrier_recovery_top: FAILED **");
		$finish;
	end

endmodule

### filelist.f
src/qcr_pkg.sv
src/qcr_ctrl.sv
src/qcr_datapath.sv
src/qpsk_costas_carrier_recovery_top.sv
src/qcr_checker.sv
dv/qpsk_costas_carrier_recovery_top_tb.sv
